/* rtl/core/rotary_encoder_interface_macros.svh */
// Assertion helpers for the rotary encoder interface
`ifndef ROTARY_ENCODER_INTERFACE_MACROS_SVH
`define ROTARY_ENCODER_INTERFACE_MACROS_SVH

// combinational or implication check, sampled on clk, off during reset
`define REI_ASSERT_HOLDS(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition this cycle forces the outcome in the next cycle
`define REI_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

/* rtl/core/rei_pkg.sv */
`timescale 1ns / 1ps
package rei_pkg;

  localparam int COUNTS_PER_STEP = 4;
  localparam int POSITION_BITS   = 16;
  localparam int STEPS_BITS      = 14;
  localparam int DEBOUNCE_BITS   = 16;

  localparam logic [DEBOUNCE_BITS-1:0] DEBOUNCE_RESET = DEBOUNCE_BITS'(100);

  // quadrature move codes
  localparam logic [1:0] MV_NONE = 2'd0;
  localparam logic [1:0] MV_CW   = 2'd1;
  localparam logic [1:0] MV_CCW  = 2'd2;
  localparam logic [1:0] MV_ILL  = 2'd3;

  typedef struct packed {
    logic pin_a;
    logic pin_b;
    logic pin_button;
    logic clear_steps;
    logic clear_press;
  } rei_sample_t;

  // index is {prev_a, prev_b, new_a, new_b}
  function automatic logic [1:0] quad_move(input logic [3:0] idx);
    logic [1:0] mv;
    case (idx)
      4'h0: mv = MV_NONE;
      4'h1: mv = MV_CW;
      4'h2: mv = MV_CCW;
      4'h3: mv = MV_ILL;
      4'h4: mv = MV_CCW;
      4'h5: mv = MV_NONE;
      4'h6: mv = MV_ILL;
      4'h7: mv = MV_CW;
      4'h8: mv = MV_CW;
      4'h9: mv = MV_ILL;
      4'hA: mv = MV_NONE;
      4'hB: mv = MV_CCW;
      4'hC: mv = MV_ILL;
      4'hD: mv = MV_CCW;
      4'hE: mv = MV_CW;
      4'hF: mv = MV_NONE;
      default: mv = MV_NONE;
    endcase
    return mv;
  endfunction

endpackage

/* rtl/core/rei_quad.sv */
`timescale 1ns / 1ps
module rei_quad (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   en,
  input  rei_pkg::rei_sample_t                   smp,
  output logic signed [rei_pkg::STEPS_BITS-1:0]  steps,
  output logic                                   illegal
);

  localparam int PosBits = rei_pkg::POSITION_BITS;
  localparam logic signed [PosBits-1:0] PosMax = {1'b0, {(PosBits-1){1'b1}}};
  localparam logic signed [PosBits-1:0] PosMin = {1'b1, {(PosBits-1){1'b0}}};
  localparam logic signed [PosBits-1:0] CountsPerStep = PosBits'(rei_pkg::COUNTS_PER_STEP);
  localparam logic signed [32:0] StepsMax = 33'((1 << (rei_pkg::STEPS_BITS - 1)) - 1);
  localparam logic signed [32:0] StepsMin = -StepsMax - 33'sd1;

  logic                      prev_a_r, prev_b_r;
  logic signed [PosBits-1:0] pos_r, pos_nxt;
  logic signed [PosBits-1:0] pos_upd, quot, rem;
  logic signed [32:0]        quot_ext;
  logic [1:0]                mv;

  always_comb begin
    mv      = rei_pkg::quad_move({prev_a_r, prev_b_r, smp.pin_a, smp.pin_b});
    illegal = (mv == rei_pkg::MV_ILL);
    pos_upd = pos_r;
    if (mv == rei_pkg::MV_CW && pos_r < PosMax) begin
      pos_upd = pos_r + PosBits'(1);
    end else if (mv == rei_pkg::MV_CCW && pos_r > PosMin) begin
      pos_upd = pos_r - PosBits'(1);
    end
    // signed / and % truncate toward zero, remainder follows the dividend
    quot     = pos_upd / CountsPerStep;
    rem      = pos_upd % CountsPerStep;
    quot_ext = 33'(quot);
    if (quot_ext > StepsMax) begin
      steps = StepsMax[rei_pkg::STEPS_BITS-1:0];
    end else if (quot_ext < StepsMin) begin
      steps = StepsMin[rei_pkg::STEPS_BITS-1:0];
    end else begin
      steps = quot_ext[rei_pkg::STEPS_BITS-1:0];
    end
    pos_nxt = (smp.clear_steps && quot != '0) ? rem : pos_upd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_a_r <= 1'b1;
      prev_b_r <= 1'b1;
      pos_r    <= '0;
    end else if (en) begin
      prev_a_r <= smp.pin_a;
      prev_b_r <= smp.pin_b;
      pos_r    <= pos_nxt;
    end
  end

endmodule

/* rtl/core/rei_debounce.sv */
`timescale 1ns / 1ps
module rei_debounce (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              en,
  input  rei_pkg::rei_sample_t              smp,
  input  logic                              cfg_we,
  input  logic [rei_pkg::DEBOUNCE_BITS-1:0] cfg_wdata,
  output logic                              level,
  output logic                              press
);

  localparam int TickBits = rei_pkg::DEBOUNCE_BITS;

  logic [TickBits-1:0] limit_r;
  logic                raw_r, raw_nxt;
  logic                stable_r, stable_nxt;
  logic                pending_r, pending_nxt;
  logic [TickBits-1:0] ticks_r, ticks_nxt;
  logic                press_r, press_nxt;

  always_comb begin
    raw_nxt     = raw_r;
    stable_nxt  = stable_r;
    pending_nxt = pending_r;
    ticks_nxt   = ticks_r;
    press_nxt   = press_r;
    if (smp.pin_button != raw_r) begin
      raw_nxt     = smp.pin_button;
      ticks_nxt   = '0;
      pending_nxt = 1'b1;
    end else if (pending_r) begin
      ticks_nxt = (ticks_r == '1) ? ticks_r : ticks_r + TickBits'(1);
      if (ticks_nxt >= limit_r) begin
        pending_nxt = 1'b0;
        if (raw_r != stable_r) begin
          stable_nxt = raw_r;
          if (!raw_r) begin
            press_nxt = 1'b1;
          end
        end
      end
    end
    level = stable_nxt;
    press = press_nxt;  // reported before the clear request
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r   <= rei_pkg::DEBOUNCE_RESET;
      raw_r     <= 1'b1;
      stable_r  <= 1'b1;
      pending_r <= 1'b0;
      ticks_r   <= '0;
      press_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        limit_r <= cfg_wdata;
      end
      if (en) begin
        raw_r     <= raw_nxt;
        stable_r  <= stable_nxt;
        pending_r <= pending_nxt;
        ticks_r   <= ticks_nxt;
        press_r   <= press_nxt && !smp.clear_press;
      end
    end
  end

endmodule

/* rtl/core/rotary_encoder_interface.sv */
`timescale 1ns / 1ps
// channel  | direction | handshake           | payload
// in_      | input     | in_valid/in_ready   | pin_a, pin_b, pin_button, clear_steps, clear_press
// out_     | output    | out_valid/out_ready | steps, press_seen, button_level, illegal_move
// cfg_     | input     | cfg_we              | cfg_wdata (debounce ticks)
//
// One sample word per clock unless out_ready stalls the result. A sample sits in the
// input register, then decoder and debounce update in one pass into the result
// register, which raises out_valid; that single pass sets the rate.
// Synchronous active-low reset: pins idle high, count zero, debounce limit 100.
// A stalled result holds; the input register takes a word while the result waits only if empty.
module rotary_encoder_interface (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic                                  in_pin_a,
  input  logic                                  in_pin_b,
  input  logic                                  in_pin_button,
  input  logic                                  in_clear_steps,
  input  logic                                  in_clear_press,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [rei_pkg::STEPS_BITS-1:0] out_steps,
  output logic                                  out_press_seen,
  output logic                                  out_button_level,
  output logic                                  out_illegal_move,
  input  logic                                  cfg_we,
  input  logic [rei_pkg::DEBOUNCE_BITS-1:0]     cfg_wdata
);

  `include "rotary_encoder_interface_macros.svh"

  rei_pkg::rei_sample_t smp_r;
  logic                 in_vld_r, in_vld_nxt;
  logic                 out_vld_r, out_vld_nxt;
  logic                 adv;

  logic signed [rei_pkg::STEPS_BITS-1:0] steps_c, steps_r;
  logic illegal_c, illegal_r;
  logic level_c, level_r;
  logic press_c, press_r;

  assign adv        = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready   = !in_vld_r || adv;
  assign in_vld_nxt = (in_valid && in_ready) ? 1'b1 : (adv ? 1'b0 : in_vld_r);
  assign out_vld_nxt = adv ? 1'b1 : (out_ready ? 1'b0 : out_vld_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      smp_r <= '{pin_a: in_pin_a, pin_b: in_pin_b, pin_button: in_pin_button,
                 clear_steps: in_clear_steps, clear_press: in_clear_press};
    end
    if (adv) begin
      steps_r   <= steps_c;
      illegal_r <= illegal_c;
      level_r   <= level_c;
      press_r   <= press_c;
    end
  end

  rei_quad u_quad (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (adv),
    .smp     (smp_r),
    .steps   (steps_c),
    .illegal (illegal_c)
  );

  rei_debounce u_debounce (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .smp       (smp_r),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .level     (level_c),
    .press     (press_c)
  );

  assign out_valid        = out_vld_r;
  assign out_steps        = steps_r;
  assign out_press_seen   = press_r;
  assign out_button_level = level_r;
  assign out_illegal_move = illegal_r;

  `REI_ASSERT_HOLDS(a_ready_when_empty, !out_vld_r |-> in_ready, "in_ready low with empty result")
  `REI_ASSERT_NEXT(a_accept_fills, in_valid && in_ready, in_vld_r, "accepted word not held")
  `REI_ASSERT_NEXT(a_drain_empties, out_vld_r && out_ready && !in_vld_r, !out_vld_r,
                   "result repeated after being taken")

endmodule
